/* sv/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEFT_W = 2;

  localparam logic [CP_W-1:0]   REPL_CHAR   = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;

  // Following bytes still expected after each kind of lead byte.
  localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
  localparam logic [LEFT_W-1:0] LEFT_SEQ2  = 2'd1;
  localparam logic [LEFT_W-1:0] LEFT_SEQ3  = 2'd2;
  localparam logic [LEFT_W-1:0] LEFT_SEQ4  = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0]   acc;
    logic [LEFT_W-1:0] left;
  } dec_state_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last;
  } dec_result_t;

endpackage

/* sv/utf8d_step.sv */
module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t        state_cur,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              frame_end,
  output dec_state_t        state_nxt,
  output dec_result_t       result
);

  logic [CP_W-1:0]   acc_shift;
  logic [LEFT_W-1:0] left_dec;

  assign acc_shift = {state_cur.acc[CP_W-7:0], byte_value[5:0]};
  assign left_dec  = state_cur.left - LEFT_W'(1);

  always_comb begin
    state_nxt         = state_cur;
    result.emit       = 1'b0;
    result.code_point = REPL_CHAR;
    result.replaced   = 1'b0;
    result.last       = frame_end;

    if (state_cur.left != LEFT_NONE) begin
      // Greedy: any byte extends the open sequence, continuation or not.
      if (left_dec == LEFT_NONE) begin
        result.emit       = 1'b1;
        result.code_point = acc_shift;
        state_nxt.acc     = '0;
        state_nxt.left    = LEFT_NONE;
      end else if (frame_end) begin
        result.emit     = 1'b1;
        result.replaced = 1'b1;
        state_nxt.acc   = '0;
        state_nxt.left  = LEFT_NONE;
      end else begin
        state_nxt.acc  = acc_shift;
        state_nxt.left = left_dec;
      end
    end else if (byte_value < ASCII_LIMIT) begin
      result.emit       = 1'b1;
      result.code_point = CP_W'(byte_value);
    end else begin
      priority if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI) begin
        state_nxt.acc  = CP_W'(byte_value[4:0]);
        state_nxt.left = LEFT_SEQ2;
      end else if (byte_value >= LEAD3_LO && byte_value <= LEAD3_HI) begin
        state_nxt.acc  = CP_W'(byte_value[3:0]);
        state_nxt.left = LEFT_SEQ3;
      end else if (byte_value >= LEAD4_LO && byte_value <= LEAD4_HI) begin
        state_nxt.acc  = CP_W'(byte_value[2:0]);
        state_nxt.left = LEFT_SEQ4;
      end else begin
        // Stray continuation byte or a lead that can never be valid.
        result.emit     = 1'b1;
        result.replaced = 1'b1;
      end
      // A valid lead on the last byte of a frame opens nothing.
      if (frame_end && !result.emit) begin
        result.emit     = 1'b1;
        result.replaced = 1'b1;
        state_nxt       = state_cur;
      end
    end
  end

endmodule

/* sv/utf8_greedy_decoder_unit.sv */
// UTF-8 to UTF-32 stream decoder. Bytes arrive one per transfer on the in_
// channel, with in_frame_end on the last byte of a frame; each transfer that
// completes a code point, hits a bad byte or closes a frame gives one result
// on the out_ channel, and out_last_out marks the frame's final result. The
// block takes one byte per cycle with no bubbles: a byte is registered, then
// decoded against the sequence state in one step into the result register,
// from which the result is offered on the out_ channel. Input is
// held back only while the result register is full and not being taken.
module utf8_greedy_decoder_unit
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              in_frame_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic              out_replaced,
  output logic              out_last_out
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_fe_r;
  logic              s1_go;

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t result;

  logic            out_valid_r;
  logic [CP_W-1:0] out_cp_r;
  logic            out_repl_r;
  logic            out_last_r;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_value;
      s1_fe_r   <= in_frame_end;
    end
  end

  utf8d_step u_step (
    .state_cur  (state_r),
    .byte_value (s1_byte_r),
    .frame_end  (s1_fe_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && result.emit) begin
      out_cp_r   <= result.code_point;
      out_repl_r <= result.replaced;
      out_last_r <= result.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_replaced   = out_repl_r;
  assign out_last_out   = out_last_r;

`ifndef SYNTHESIS
  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_repl_r |-> out_cp_r == REPL_CHAR)
    else $error("replacement result carries a value other than U+FFFD");

  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_fe_r |=> state_r.left == LEFT_NONE)
    else $error("sequence still open after the last byte of a frame");

  a_frame_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_fe_r |-> result.emit && result.last)
    else $error("last byte of a frame gave no final result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input held back with no full result register");
`endif

endmodule

/* verif/tb.sv */
module tb;
  import utf8d_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned DRAIN_AT    = 500;
  localparam int unsigned BYTE_COUNT  = 950;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              frame_end;
    int unsigned       idle_cycles;
    bit                drain;
  } byte_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte_value = '0;
  logic              in_frame_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   out_code_point;
  logic              out_replaced;
  logic              out_last_out;

  byte_item_t  byte_stream[$];
  dec_result_t expected_cps[$];

  // Decoder state as the testbench tracks it.
  logic [CP_W-1:0]   dec_acc = '0;
  logic [LEFT_W-1:0] dec_left = LEFT_NONE;

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned tx_waited = 0;
  int unsigned rx_idle = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned n_bytes_in = 0;
  int unsigned n_results = 0;
  int unsigned n_replaced = 0;
  int unsigned n_frames = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  utf8_greedy_decoder_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_replaced   (out_replaced),
    .out_last_out   (out_last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the tracked state by one byte and returns the code point it
  // yields, if any.
  function automatic dec_result_t decode_byte(input logic [BYTE_W-1:0] b, input logic fe);
    dec_result_t       r;
    logic [CP_W-1:0]   payload;
    logic [LEFT_W-1:0] opens;
    r = '0;
    payload = '0;
    opens = LEFT_NONE;
    if (dec_left != LEFT_NONE) begin
      // Following bytes are taken as they come, continuation or not.
      dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
      dec_left = dec_left - 1'b1;
      if (dec_left == LEFT_NONE) begin
        r.emit = 1'b1;
        r.code_point = dec_acc;
        r.last = fe;
        dec_acc = '0;
      end else if (fe) begin
        dec_acc = '0;
        dec_left = LEFT_NONE;
        r.emit = 1'b1;
        r.code_point = REPL_CHAR;
        r.replaced = 1'b1;
        r.last = 1'b1;
      end
    end else if (b < ASCII_LIMIT) begin
      r.emit = 1'b1;
      r.code_point = CP_W'(b);
      r.last = fe;
    end else begin
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        opens = LEFT_SEQ2;
        payload = CP_W'(b[4:0]);
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        opens = LEFT_SEQ3;
        payload = CP_W'(b[3:0]);
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        opens = LEFT_SEQ4;
        payload = CP_W'(b[2:0]);
      end
      if (opens == LEFT_NONE || fe) begin
        r.emit = 1'b1;
        r.code_point = REPL_CHAR;
        r.replaced = 1'b1;
        r.last = fe;
      end else begin
        dec_acc = payload;
        dec_left = opens;
      end
    end
    return r;
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic fe);
    byte_item_t item;
    if (byte_stream.size() % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    item.value = b;
    item.frame_end = fe;
    item.idle_cycles = tx_calm ? 0 : $urandom_range(0, 18);
    item.drain = (byte_stream.size() == DRAIN_AT);
    byte_stream.push_back(item);
  endfunction

  always @(posedge clk) begin : drive_bytes
    dec_result_t res;
    byte_item_t  nxt;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_value <= '0;
      in_frame_end <= 1'b0;
      tx_waited = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        res = decode_byte(in_byte_value, in_frame_end);
        if (res.emit) expected_cps.push_back(res);
        n_bytes_in <= n_bytes_in + 1;
        offer = 1'b0;
      end
      if (!offer && byte_stream.size() != 0) begin
        // A drain item waits until every outstanding result has come out.
        if (byte_stream[0].drain && expected_cps.size() != 0) begin
          tx_waited = 0;
        end else if (tx_waited < byte_stream[0].idle_cycles) begin
          tx_waited++;
        end else begin
          nxt = byte_stream.pop_front();
          in_byte_value <= nxt.value;
          in_frame_end <= nxt.frame_end;
          offer = 1'b1;
          tx_waited = 0;
        end
      end
      in_valid <= offer;
    end
  end

  // Long output stalls so that the block fills up and pushes back on input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && n_bytes_in >= (holds_done == 0 ? 300 : 700)) begin
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin : take_results
    dec_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_idle = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cps.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, got cp %h repl %b last %b",
                   $time, out_code_point, out_replaced, out_last_out);
          mismatches++;
        end else begin
          want = expected_cps.pop_front();
          if (out_code_point !== want.code_point) begin
            $display("%0t: code_point mismatch: expected %h, got %h",
                     $time, want.code_point, out_code_point);
            mismatches++;
          end
          if (out_replaced !== want.replaced) begin
            $display("%0t: replaced mismatch: expected %b, got %b",
                     $time, want.replaced, out_replaced);
            mismatches++;
          end
          if (out_last_out !== want.last) begin
            $display("%0t: last_out mismatch: expected %b, got %b",
                     $time, want.last, out_last_out);
            mismatches++;
          end
        end
        n_results++;
        if (out_replaced) n_replaced++;
        if (out_last_out) n_frames++;
        if (n_results % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_idle = rx_calm ? 0 : $urandom_range(0, 18);
      end else if (rx_idle != 0) begin
        rx_idle--;
      end
      out_ready <= (rx_idle == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int          kind;
    int          conts;
    int          sent;
    int          k;
    bit          cut;
    logic        closes;
    logic [7:0]  lead;
    logic [7:0]  cont;

    // Extremes of single bytes: ASCII ends, stray continuations, bad leads.
    add_byte(8'h00, 1'b1); add_byte(8'h7F, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hBF, 1'b0); add_byte(8'hC0, 1'b0); add_byte(8'hC1, 1'b0);
    add_byte(8'hF5, 1'b0); add_byte(8'hFF, 1'b1);
    // A well-formed two-byte sequence, and sequences of every length completed by greedy non-continuation bytes.
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hDF, 1'b0); add_byte(8'h41, 1'b0);
    add_byte(8'hE0, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    // A lead byte that ends the frame, then sequences cut short by the frame end.
    add_byte(8'hC3, 1'b1);
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b1);
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b1);

    while (byte_stream.size() < BYTE_COUNT) begin
      kind = $urandom_range(0, 99);
      closes = ($urandom_range(0, 7) == 0);
      if (kind < 30) begin
        add_byte(8'($urandom_range(0, 127)), closes);
      end else if (kind < 82) begin
        if (kind < 50) begin
          lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
          conts = 1;
        end else if (kind < 68) begin
          lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
          conts = 2;
        end else begin
          lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
          conts = 3;
        end
        cut = ($urandom_range(0, 9) == 0);
        sent = cut ? $urandom_range(0, conts - 1) : conts;
        // A cut sequence usually ends its frame; otherwise the next bytes
        // are swallowed as its continuation.
        if (cut) closes = ($urandom_range(0, 3) != 0);
        add_byte(lead, (sent == 0) ? closes : 1'b0);
        for (k = 1; k <= sent; k++) begin
          cont = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(8'hBF, 8'h80));
          add_byte(cont, (k == sent) ? closes : 1'b0);
        end
      end else begin
        add_byte(8'($urandom_range(0, 255)), closes);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || in_valid || expected_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Decoded %0d bytes into %0d code points (%0d replacements) over %0d frames.",
             n_bytes_in, n_results, n_replaced, n_frames);
    $display("Output was held off %0d times for %0d cycles; input paused once to drain.",
             holds_done, LONG_HOLD);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
